@@ src/slshd_pkg.sv @@
package slshd_pkg;

  typedef enum logic [1:0] {
    OP_OBSERVE     = 2'd0,
    OP_MODE_CHANGE = 2'd1,
    OP_CHECK       = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_ATOMIC = 2'd2,
    KIND_OTHER  = 2'd3
  } mem_kind_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_DETECT_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_STORE_LIMIT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOAD_LIMIT    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_USER_INTERVAL = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MODE_GATE     = 3'd4;

  localparam logic       DETECT_STORE = 1'b0;
  localparam logic       DETECT_LOAD  = 1'b1;

  localparam logic [4:0] STORE_LIMIT_RST = 5'd16;
  localparam logic [6:0] LOAD_LIMIT_RST  = 7'd64;
  localparam logic [7:0] USER_INTERVAL_RST = 8'd0;
  localparam logic       MODE_GATE_RST   = 1'b1;
  localparam logic [7:0] STREAK_MAX      = 8'hFF;

  // Key layout of a store entry: address, data, access size, byte mask.
  localparam int unsigned StoreKeyW = 64 + 64 + 4 + 8;
  localparam int unsigned LoadKeyW  = 64;

  typedef struct packed {
    logic valid;
    logic done;
  } tok_ctrl_t;

endpackage

@@ src/spin_loop_store_history_detector.sv @@
// Spin-loop detector. Observe and mode-change requests are taken one per cycle
// while busy is low; an observed store (or, in load mode, load) walks down a row
// of entry cells, one cell per cycle, and leaves the row after the last cell. A
// check request raises busy until every observed access still walking the rows
// has left them; the verdict appears on the result ports, marked by
// result_valid_o, for exactly one cycle. The receiver cannot stall results.
// Configuration writes take effect at once and must be made while busy is low
// and no observed access is still in flight.
module spin_loop_store_history_detector #(
  parameter int unsigned STORE_DEPTH = 16,
  parameter int unsigned LOAD_DEPTH  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          op_i,
  input  logic [1:0]                          mem_kind_i,
  input  logic [63:0]                         phys_addr_i,
  input  logic signed [63:0]                  store_value_i,
  input  logic [7:0]                          byte_mask_i,
  input  logic [3:0]                          access_size_i,
  input  logic                                supervisor_i,
  input  logic                                cfg_we_i,
  input  logic [slshd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [slshd_pkg::CfgDataW-1:0]      cfg_data_i,
  output logic                                result_valid_o,
  output logic                                spin_detected_o,
  output logic [4:0]                          distinct_stores_o,
  output logic [6:0]                          distinct_loads_o
);

  localparam int unsigned StFillW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned LdFillW = $clog2(LOAD_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e                          state_q;
  logic                            detect_mode_q;
  logic [4:0]                      store_limit_q;
  logic [6:0]                      load_limit_q;
  logic [7:0]                      uic_q;
  logic                            gate_q;
  logic                            mc_q;
  logic [7:0]                      streak_q;
  logic [7:0]                      streak_d;
  logic [7:0]                      streak_inc;
  logic [7:0]                      streak_nx;
  logic                            sup_q;
  logic                            result_valid_q;
  logic                            spin_q;
  logic [4:0]                      stores_q;
  logic [6:0]                      loads_q;
  logic                            accept;
  logic                            st_push;
  logic                            ld_push;
  logic                            finish;
  logic                            spin;
  logic                            st_low;
  logic                            ld_low;
  logic                            st_idle;
  logic                            ld_idle;
  logic [StFillW-1:0]              st_fill;
  logic [LdFillW-1:0]              ld_fill;
  logic [slshd_pkg::StoreKeyW-1:0] st_key;

  assign busy    = (state_q == ST_DRAIN);
  assign accept  = start && !busy;
  assign st_push = accept && (op_i == slshd_pkg::OP_OBSERVE) &&
                   (mem_kind_i == slshd_pkg::KIND_STORE);
  assign ld_push = accept && (op_i == slshd_pkg::OP_OBSERVE) &&
                   (mem_kind_i == slshd_pkg::KIND_LOAD) &&
                   (detect_mode_q == slshd_pkg::DETECT_LOAD);
  assign finish  = (state_q == ST_DRAIN) && st_idle && ld_idle;
  assign st_key  = {phys_addr_i, store_value_i, access_size_i, byte_mask_i};

  slshd_chain #(
    .DEPTH (STORE_DEPTH),
    .KEY_W (slshd_pkg::StoreKeyW),
    .LIM_W (5),
    .FILL_W(StFillW)
  ) u_store_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (st_push),
    .key_i  (st_key),
    .limit_i(store_limit_q),
    .clear_i(finish),
    .fill_o (st_fill),
    .idle_o (st_idle)
  );

  slshd_chain #(
    .DEPTH (LOAD_DEPTH),
    .KEY_W (slshd_pkg::LoadKeyW),
    .LIM_W (7),
    .FILL_W(LdFillW)
  ) u_load_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (ld_push),
    .key_i  (phys_addr_i),
    .limit_i(load_limit_q),
    .clear_i(finish),
    .fill_o (ld_fill),
    .idle_o (ld_idle)
  );

  always_comb begin
    spin       = 1'b0;
    streak_d   = streak_q;
    streak_nx  = '0;
    st_low     = 32'(st_fill) < 32'(store_limit_q);
    ld_low     = 32'(ld_fill) < 32'(load_limit_q);
    streak_inc = (streak_q == slshd_pkg::STREAK_MAX) ? streak_q : streak_q + 8'd1;
    if (detect_mode_q == slshd_pkg::DETECT_STORE) begin
      if (uic_q == '0) begin
        spin = st_low;
      end else if (sup_q) begin
        spin     = st_low && !mc_q;
        streak_d = '0;
      end else begin
        streak_nx = st_low ? streak_inc : '0;
        if (!mc_q && (streak_nx == uic_q)) begin
          spin     = 1'b1;
          streak_d = '0;
        end else if (mc_q) begin
          streak_d = '0;
        end else begin
          streak_d = streak_nx;
        end
      end
    end else if (!gate_q || !mc_q) begin
      spin = sup_q ? st_low : (st_low && ld_low);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_mode_q <= slshd_pkg::DETECT_STORE;
      store_limit_q <= slshd_pkg::STORE_LIMIT_RST;
      load_limit_q  <= slshd_pkg::LOAD_LIMIT_RST;
      uic_q         <= slshd_pkg::USER_INTERVAL_RST;
      gate_q        <= slshd_pkg::MODE_GATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        slshd_pkg::CFG_DETECT_MODE:   detect_mode_q <= cfg_data_i[0];
        slshd_pkg::CFG_STORE_LIMIT:   store_limit_q <= cfg_data_i[4:0];
        slshd_pkg::CFG_LOAD_LIMIT:    load_limit_q  <= cfg_data_i[6:0];
        slshd_pkg::CFG_USER_INTERVAL: uic_q         <= cfg_data_i;
        slshd_pkg::CFG_MODE_GATE:     gate_q        <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      mc_q           <= 1'b0;
      streak_q       <= '0;
      sup_q          <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= finish;
      case (state_q)
        ST_IDLE: begin
          if (accept && (op_i == slshd_pkg::OP_MODE_CHANGE)) begin
            mc_q     <= 1'b1;
            streak_q <= '0;
          end else if (accept && (op_i == slshd_pkg::OP_CHECK)) begin
            sup_q   <= supervisor_i;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            mc_q     <= 1'b0;
            streak_q <= streak_d;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      spin_q   <= spin;
      stores_q <= 5'(st_fill);
      loads_q  <= 7'(ld_fill);
    end
  end

  assign result_valid_o    = result_valid_q;
  assign spin_detected_o   = spin_q;
  assign distinct_stores_o = stores_q;
  assign distinct_loads_o  = loads_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> $past(state_q == ST_DRAIN) && (state_q == ST_IDLE))
    else $error("result issued without a finished check");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q && $past(detect_mode_q == slshd_pkg::DETECT_LOAD) &&
    $past(gate_q) && $past(mc_q) |-> !spin_q)
    else $error("load-mode verdict not suppressed after a mode change");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q && spin_q && $past(detect_mode_q == slshd_pkg::DETECT_STORE) &&
    ($past(uic_q) != '0) |-> (streak_q == '0))
    else $error("user streak not cleared after a spin verdict");

endmodule

@@ src/slshd_cell.sv @@
module slshd_cell #(
  parameter int unsigned KEY_W = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                allow_i,
  input  logic                prev_occ_i,
  input  slshd_pkg::tok_ctrl_t tok_i,
  input  logic [KEY_W-1:0]    key_i,
  output slshd_pkg::tok_ctrl_t tok_o,
  output logic [KEY_W-1:0]    key_o,
  output logic                occ_o,
  output logic                ins_o
);

  logic [KEY_W-1:0]     entry_q;
  logic                 occ_q;
  logic                 occ_d;
  logic                 match;
  logic                 ins;
  slshd_pkg::tok_ctrl_t tok_q;
  slshd_pkg::tok_ctrl_t tok_d;
  logic [KEY_W-1:0]     key_q;

  assign match = occ_q && (entry_q == key_i);
  assign ins   = tok_i.valid && !tok_i.done && !occ_q && prev_occ_i && allow_i;
  assign occ_d = clear_i ? 1'b0 : (occ_q || ins);

  always_comb begin
    tok_d.valid = tok_i.valid;
    tok_d.done  = tok_i.done || match || ins;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      tok_q <= '0;
    end else begin
      occ_q <= occ_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_i;
    if (ins) begin
      entry_q <= key_i;
    end
  end

  assign tok_o = tok_q;
  assign key_o = key_q;
  assign occ_o = occ_q;
  assign ins_o = ins;

endmodule

@@ src/slshd_chain.sv @@
module slshd_chain #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned KEY_W  = 64,
  parameter int unsigned LIM_W  = 5,
  parameter int unsigned FILL_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [LIM_W-1:0]  limit_i,
  input  logic              clear_i,
  output logic [FILL_W-1:0] fill_o,
  output logic              idle_o
);

  localparam int unsigned PendW = $clog2(DEPTH + 1);

  slshd_pkg::tok_ctrl_t tok [DEPTH+1];
  logic [KEY_W-1:0]     key [DEPTH+1];
  logic [DEPTH-1:0]     occ;
  logic [DEPTH-1:0]     ins;
  logic [DEPTH-1:0]     allow;
  logic [DEPTH-1:0]     prev_occ;
  logic [FILL_W-1:0]    fill_q;
  logic [FILL_W-1:0]    fill_d;
  logic [PendW-1:0]     pend_q;
  logic [PendW-1:0]     pend_d;

  assign tok[0].valid = push_i;
  assign tok[0].done  = 1'b0;
  assign key[0]       = key_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign allow[i] = 32'(i) < 32'(limit_i);
    if (i == 0) begin : g_head
      assign prev_occ[i] = 1'b1;
    end else begin : g_body
      assign prev_occ[i] = occ[i-1];
    end

    slshd_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clear_i   (clear_i),
      .allow_i   (allow[i]),
      .prev_occ_i(prev_occ[i]),
      .tok_i     (tok[i]),
      .key_i     (key[i]),
      .tok_o     (tok[i+1]),
      .key_o     (key[i+1]),
      .occ_o     (occ[i]),
      .ins_o     (ins[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (clear_i) begin
      fill_d = '0;
    end else if (|ins) begin
      fill_d = fill_q + FILL_W'(1);
    end
    pend_d = pend_q;
    if (push_i && !tok[DEPTH].valid) begin
      pend_d = pend_q + PendW'(1);
    end else if (!push_i && tok[DEPTH].valid) begin
      pend_d = pend_q - PendW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pend_q <= '0;
    end else begin
      fill_q <= fill_d;
      pend_q <= pend_d;
    end
  end

  assign fill_o = fill_q;
  assign idle_o = (pend_q == '0);

  // The occupied cells always form a prefix of the row, one per recorded entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ) == int'(fill_q))
    else $error("occupied cell count differs from fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ + DEPTH'(1)) & occ) == '0)
    else $error("occupied cells are not contiguous from the head");

endmodule

@@ sim/tb_spin_loop_store_history_detector.sv @@
module tb_spin_loop_store_history_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH  = 16;
  localparam int unsigned LOAD_DEPTH   = 64;
  localparam int unsigned POOL_SIZE    = 96;
  localparam int unsigned DRAIN_CYCLES = LOAD_DEPTH + 4;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  kind;
    logic [63:0] addr;
    logic [63:0] data;
    logic [7:0]  mask;
    logic [3:0]  size;
    logic        sup;
  } req_t;

  typedef struct packed {
    logic       spin;
    logic [4:0] stores;
    logic [6:0] loads;
  } verdict_t;

  class verdict_board;
    logic [63:0] st_addr [STORE_DEPTH];
    logic [63:0] st_data [STORE_DEPTH];
    logic [11:0] st_shape[STORE_DEPTH];
    logic [63:0] ld_addr [LOAD_DEPTH];
    int unsigned st_fill;
    int unsigned ld_fill;
    bit          mode_changed;
    int unsigned streak;
    bit          detect_load;
    int unsigned store_limit;
    int unsigned load_limit;
    int unsigned interval_need;
    bit          gate;
    verdict_t    verdict_q[$];
    int unsigned mismatches;

    function new();
      st_fill       = 0;
      ld_fill       = 0;
      mode_changed  = 1'b0;
      streak        = 0;
      detect_load   = (slshd_pkg::DETECT_STORE == slshd_pkg::DETECT_LOAD);
      store_limit   = slshd_pkg::STORE_LIMIT_RST;
      load_limit    = slshd_pkg::LOAD_LIMIT_RST;
      interval_need = slshd_pkg::USER_INTERVAL_RST;
      gate          = slshd_pkg::MODE_GATE_RST;
      mismatches    = 0;
    endfunction

    function void apply_config(logic [slshd_pkg::CfgIdxW-1:0] idx,
                               logic [slshd_pkg::CfgDataW-1:0] d);
      case (idx)
        slshd_pkg::CFG_DETECT_MODE:   detect_load = (d[0] == slshd_pkg::DETECT_LOAD);
        slshd_pkg::CFG_STORE_LIMIT:   store_limit = d[4:0];
        slshd_pkg::CFG_LOAD_LIMIT:    load_limit = d[6:0];
        slshd_pkg::CFG_USER_INTERVAL: interval_need = d;
        slshd_pkg::CFG_MODE_GATE:     gate = d[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    function void note_request(req_t r);
      verdict_t    v;
      logic [11:0] shape;
      bit          low;
      bit          found;
      int unsigned i;
      shape = {r.size, r.mask};
      found = 1'b0;
      case (r.op)
        slshd_pkg::OP_OBSERVE: begin
          if (r.kind == slshd_pkg::KIND_STORE) begin
            if (st_fill < store_limit && st_fill < STORE_DEPTH) begin
              for (i = 0; i < st_fill; i++)
                if (st_addr[i] == r.addr && st_data[i] == r.data && st_shape[i] == shape)
                  found = 1'b1;
              if (!found) begin
                st_addr[st_fill]  = r.addr;
                st_data[st_fill]  = r.data;
                st_shape[st_fill] = shape;
                st_fill++;
              end
            end
          end else if (r.kind == slshd_pkg::KIND_LOAD && detect_load) begin
            if (ld_fill < load_limit && ld_fill < LOAD_DEPTH) begin
              for (i = 0; i < ld_fill; i++)
                if (ld_addr[i] == r.addr) found = 1'b1;
              if (!found) begin
                ld_addr[ld_fill] = r.addr;
                ld_fill++;
              end
            end
          end
        end
        slshd_pkg::OP_MODE_CHANGE: begin
          mode_changed = 1'b1;
          streak = 0;
        end
        slshd_pkg::OP_CHECK: begin
          low = st_fill < store_limit;
          v.spin = 1'b0;
          if (!detect_load) begin
            if (interval_need == 0) begin
              v.spin = low;
            end else if (r.sup) begin
              v.spin = low && !mode_changed;
              streak = 0;
            end else begin
              if (low) begin
                if (streak < slshd_pkg::STREAK_MAX) streak++;
              end else begin
                streak = 0;
              end
              if (!mode_changed && streak == interval_need) begin
                v.spin = 1'b1;
                streak = 0;
              end else if (mode_changed) begin
                streak = 0;
              end
            end
          end else if (!gate || !mode_changed) begin
            v.spin = r.sup ? low : (low && ld_fill < load_limit);
          end
          v.stores = 5'(st_fill);
          v.loads  = 7'(ld_fill);
          verdict_q.push_back(v);
          st_fill = 0;
          ld_fill = 0;
          mode_changed = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: spin=%0d stores=%0d loads=%0d",
                   got.spin, got.stores, got.loads);
        return;
      end
      want = verdict_q.pop_front();
      if (got.spin !== want.spin || got.stores !== want.stores || got.loads !== want.loads) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result differs: spin %0d/%0d stores %0d/%0d loads %0d/%0d (exp/act)",
                   want.spin, got.spin, want.stores, got.stores, want.loads, got.loads);
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [1:0]                     op_i;
  logic [1:0]                     mem_kind_i;
  logic [63:0]                    phys_addr_i;
  logic signed [63:0]             store_value_i;
  logic [7:0]                     byte_mask_i;
  logic [3:0]                     access_size_i;
  logic                           supervisor_i;
  logic                           cfg_we_i;
  logic [slshd_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [slshd_pkg::CfgDataW-1:0] cfg_data_i;
  logic                           result_valid_o;
  logic                           spin_detected_o;
  logic [4:0]                     distinct_stores_o;
  logic [6:0]                     distinct_loads_o;

  verdict_board sb;
  int unsigned  cycles;
  int unsigned  issued;
  bit           idle_on;

  logic [63:0] addr_pool [POOL_SIZE];
  logic [63:0] data_pool [4];
  logic [7:0]  mask_pool [POOL_SIZE];
  logic [3:0]  size_pool [POOL_SIZE];

  spin_loop_store_history_detector #(
    .STORE_DEPTH(STORE_DEPTH),
    .LOAD_DEPTH (LOAD_DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .mem_kind_i       (mem_kind_i),
    .phys_addr_i      (phys_addr_i),
    .store_value_i    (store_value_i),
    .byte_mask_i      (byte_mask_i),
    .access_size_i    (access_size_i),
    .supervisor_i     (supervisor_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .spin_detected_o  (spin_detected_o),
    .distinct_stores_o(distinct_stores_o),
    .distinct_loads_o (distinct_loads_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("spin_loop_store_history_detector: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1)
      sb.check_verdict('{spin_detected_o, distinct_stores_o, distinct_loads_o});
  end

  function automatic req_t make_req(logic [1:0] op, logic [1:0] kind, logic [63:0] addr,
                                    logic [63:0] data, logic [7:0] mask, logic [3:0] size,
                                    logic sup);
    req_t r;
    r.op   = op;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    r.mask = mask;
    r.size = size;
    r.sup  = sup;
    return r;
  endfunction

  function automatic req_t make_noise();
    return make_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), {$urandom, $urandom},
                    {$urandom, $urandom}, 8'($urandom), 4'($urandom), 1'($urandom));
  endfunction

  function automatic req_t make_check(logic sup);
    req_t r;
    r = make_noise();
    r.op = slshd_pkg::OP_CHECK;
    r.sup = sup;
    return r;
  endfunction

  function automatic req_t make_access(int unsigned span);
    req_t        r;
    int unsigned k;
    int unsigned pick;
    k = $urandom_range(0, span - 1);
    pick = $urandom_range(0, 99);
    r = make_noise();
    r.op = slshd_pkg::OP_OBSERVE;
    r.kind = pick < 45 ? slshd_pkg::KIND_STORE : pick < 80 ? slshd_pkg::KIND_LOAD :
             pick < 90 ? slshd_pkg::KIND_ATOMIC : slshd_pkg::KIND_OTHER;
    r.addr = addr_pool[k];
    r.data = $urandom_range(0, 9) < 7 ? data_pool[k % 4] : data_pool[$urandom_range(0, 3)];
    if ($urandom_range(0, 99) < 85) begin
      r.mask = mask_pool[k];
      r.size = size_pool[k];
    end
    return r;
  endfunction

  function automatic void refresh_pools();
    int unsigned i;
    int unsigned pick;
    for (i = 0; i < POOL_SIZE; i++) begin
      pick = $urandom_range(0, 19);
      addr_pool[i] = pick == 0 ? '1 : pick == 1 ? '0 : {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0: mask_pool[i] = 8'hFF;
        1: mask_pool[i] = 8'h0F;
        2: mask_pool[i] = 8'h03;
        3: mask_pool[i] = 8'h01;
        default: mask_pool[i] = 8'($urandom);
      endcase
      size_pool[i] = 4'(1 << $urandom_range(0, 3));
    end
    for (i = 0; i < 4; i++) data_pool[i] = {$urandom, $urandom};
  endfunction

  task automatic send_request(input req_t r);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(0, 49) == 0 ? $urandom_range(4, 70) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    op_i          <= r.op;
    mem_kind_i    <= r.kind;
    phys_addr_i   <= r.addr;
    store_value_i <= r.data;
    byte_mask_i   <= r.mask;
    access_size_i <= r.size;
    supervisor_i  <= r.sup;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
    if (r.op != OP_UNUSED) issued++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [slshd_pkg::CfgIdxW-1:0] idx,
                           input logic [slshd_pkg::CfgDataW-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.apply_config(idx, d);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_interval();
    int unsigned n;
    int unsigned span;
    int unsigned pick;
    int unsigned i;
    pick = $urandom_range(0, 99);
    n = pick < 70 ? $urandom_range(0, 12) : pick < 90 ? $urandom_range(13, 30) :
        $urandom_range(40, 90);
    span = $urandom_range(1, POOL_SIZE);
    if ($urandom_range(0, 2) == 0) refresh_pools();
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) send_request(make_noise());
      else if (pick < 7) send_request(make_req(slshd_pkg::OP_MODE_CHANGE, 2'($urandom),
                                               {$urandom, $urandom}, {$urandom, $urandom},
                                               8'($urandom), 4'($urandom), 1'($urandom)));
      else send_request(make_access(span));
    end
    send_request(make_check($urandom_range(0, 99) < 25));
  endtask

  task automatic run_phase(input logic detect, input logic [7:0] slim, input logic [7:0] llim,
                           input logic [7:0] need, input logic gate, input bit quiet);
    int unsigned first;
    drain();
    write_cfg(slshd_pkg::CFG_DETECT_MODE, {7'd0, detect});
    write_cfg(slshd_pkg::CFG_STORE_LIMIT, slim);
    write_cfg(slshd_pkg::CFG_LOAD_LIMIT, llim);
    write_cfg(slshd_pkg::CFG_USER_INTERVAL, need);
    write_cfg(slshd_pkg::CFG_MODE_GATE, {7'd0, gate});
    // A write to an index past the last register must leave every register alone.
    write_cfg(slshd_pkg::CFG_MODE_GATE + slshd_pkg::CfgIdxW'($urandom_range(1, 3)),
              8'($urandom));
    idle_on = !quiet;
    first = issued;
    while (issued - first < PHASE_ITEMS) run_interval();
  endtask

  // Builds the user streak up to just below the limit, lets it saturate after the
  // required count is lowered, then raises the count to meet the saturated streak.
  task automatic run_streak_saturation();
    int unsigned i;
    drain();
    write_cfg(slshd_pkg::CFG_DETECT_MODE, {7'd0, slshd_pkg::DETECT_STORE});
    write_cfg(slshd_pkg::CFG_STORE_LIMIT, 8'(slshd_pkg::STORE_LIMIT_RST));
    write_cfg(slshd_pkg::CFG_USER_INTERVAL, slshd_pkg::STREAK_MAX);
    idle_on = 1'b1;
    send_request(make_check(1'b1));
    for (i = 0; i < 254; i++) send_request(make_check(1'b0));
    drain();
    write_cfg(slshd_pkg::CFG_USER_INTERVAL, 8'd1);
    repeat (2) send_request(make_check(1'b0));
    drain();
    write_cfg(slshd_pkg::CFG_USER_INTERVAL, slshd_pkg::STREAK_MAX);
    send_request(make_check(1'b0));
  endtask

  initial begin
    int unsigned p;
    logic [7:0]  need;
    sb = new();
    cycles = 0;
    issued = 0;
    idle_on = 1'b1;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    op_i          <= slshd_pkg::OP_OBSERVE;
    mem_kind_i    <= slshd_pkg::KIND_LOAD;
    phys_addr_i   <= '0;
    store_value_i <= '0;
    byte_mask_i   <= '0;
    access_size_i <= '0;
    supervisor_i  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= slshd_pkg::CFG_DETECT_MODE;
    cfg_data_i    <= '0;
    refresh_pools();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(make_req(slshd_pkg::OP_OBSERVE, slshd_pkg::KIND_STORE, '0, '0, 8'h00, 4'h0,
                          1'b0));
    send_request(make_req(slshd_pkg::OP_OBSERVE, slshd_pkg::KIND_STORE, '1,
                          64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 4'd8, 1'b1));
    send_request(make_req(slshd_pkg::OP_OBSERVE, slshd_pkg::KIND_STORE, '1,
                          64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 4'd8, 1'b0));
    send_request(make_req(slshd_pkg::OP_OBSERVE, slshd_pkg::KIND_STORE, '1,
                          64'h8000_0000_0000_0000, 8'hFF, 4'd8, 1'b0));
    send_request(make_req(slshd_pkg::OP_OBSERVE, slshd_pkg::KIND_STORE, '1,
                          64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, 4'hF, 1'b0));
    send_request(make_req(slshd_pkg::OP_OBSERVE, slshd_pkg::KIND_STORE, '1,
                          64'h7FFF_FFFF_FFFF_FFFF, 8'h7F, 4'd8, 1'b0));
    send_request(make_req(slshd_pkg::OP_OBSERVE, slshd_pkg::KIND_LOAD, '1, '1, 8'hFF, 4'hF,
                          1'b1));
    send_request(make_req(slshd_pkg::OP_OBSERVE, slshd_pkg::KIND_ATOMIC,
                          64'h5555_5555_5555_5555, '1, 8'hFF, 4'd8, 1'b0));
    send_request(make_req(slshd_pkg::OP_OBSERVE, slshd_pkg::KIND_OTHER,
                          64'hAAAA_AAAA_AAAA_AAAA, '1, 8'hFF, 4'd8, 1'b0));
    send_request(make_req(OP_UNUSED, slshd_pkg::KIND_STORE, 64'h1234_5678_9ABC_DEF0, '1,
                          8'hFF, 4'd8, 1'b1));
    send_request(make_check(1'b0));
    send_request(make_req(slshd_pkg::OP_MODE_CHANGE, slshd_pkg::KIND_STORE, '0, '0, 8'h00,
                          4'h0, 1'b0));
    send_request(make_check(1'b1));
    send_request(make_check(1'b0));

    run_phase(slshd_pkg::DETECT_STORE, 8'd16, 8'd64, 8'd0, 1'b1, 1'b1);
    run_phase(slshd_pkg::DETECT_STORE, 8'd4, 8'd64, 8'd3, 1'b1, 1'b0);
    run_phase(slshd_pkg::DETECT_STORE, 8'd0, 8'd0, 8'd1, 1'b0, 1'b0);
    run_streak_saturation();
    run_phase(slshd_pkg::DETECT_LOAD, 8'd16, 8'd64, 8'd0, 1'b1, 1'b0);
    run_phase(slshd_pkg::DETECT_LOAD, 8'd5, 8'd12, 8'd0, 1'b0, 1'b0);
    run_phase(slshd_pkg::DETECT_LOAD, 8'd31, 8'd127, 8'd0, 1'b1, 1'b0);
    run_phase(slshd_pkg::DETECT_STORE, 8'd16, 8'd64, 8'd2, 1'b0, 1'b0);
    run_phase(slshd_pkg::DETECT_LOAD, 8'd0, 8'd0, 8'd7, 1'b1, 1'b0);
    run_phase(slshd_pkg::DETECT_STORE, 8'd6, 8'd30, 8'd1, 1'b1, 1'b0);
    for (p = 0; p < 4; p++) begin
      case ($urandom_range(0, 2))
        0: need = 8'd0;
        1: need = 8'($urandom_range(1, 5));
        default: need = 8'($urandom_range(6, 255));
      endcase
      run_phase(1'($urandom), 8'($urandom_range(0, 16)), 8'($urandom_range(0, 64)), need,
                1'($urandom), 1'b0);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("spin_loop_store_history_detector: match");
    end else begin
      $display("spin_loop_store_history_detector: mismatch");
    end
    $finish;
  end

endmodule
